[rtl/svps_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the spiral valid point search core.
// No dependencies; used by svps_walker and spiral_valid_point_search_core.
package svps_pkg;

	// fixed field widths
	localparam int COORD_W  = 8;    // pixel column / row
	localparam int DIM_W    = 9;    // image and box sizes
	localparam int SPW      = 11;   // signed spiral offset and centre-relative pixel
	localparam int LIM_W    = 2 * DIM_W;  // step count up to max(box)^2
	localparam int FLT_W    = 32;
	localparam int S_DATA_W = 136;  // 130 payload bits padded to whole bytes
	localparam int M_DATA_W = 16;
	localparam int CFG_AW   = 3;

	// configuration register indexes
	typedef enum logic {
		REG_IMAGE_COLS = 1'b0,
		REG_IMAGE_ROWS = 1'b1
	} reg_idx_t;

	// search geometry, captured when a search word is accepted
	typedef struct packed {
		logic [COORD_W-1:0] ctr_col;
		logic [COORD_W-1:0] ctr_row;
		logic [DIM_W-1:0]   box_cols;
		logic [DIM_W-1:0]   box_rows;
		logic [DIM_W-1:0]   img_cols;
		logic [DIM_W-1:0]   img_rows;
	} geom_t;

	// walker control from the sequencer
	typedef struct packed {
		logic load;
		logic step;
	} walk_ctl_t;

	// probe of the current spiral position
	typedef struct packed {
		logic               elig;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} probe_t;

endpackage

[rtl/svps_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module svps_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 65536,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read, read data holds while re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/svps_walker.sv]
`timescale 1ns / 1ps
// Square spiral walker: spiral position and direction registers, box and image
// checks and map address of the current position. Depends on svps_pkg.
module svps_walker #(
	parameter int MAX_COLS = 256,
	parameter int MAX_ROWS = 256,
	localparam int AW = $clog2(MAX_COLS * MAX_ROWS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  svps_pkg::walk_ctl_t ctl,
	input  svps_pkg::geom_t     geom,
	output svps_pkg::probe_t    probe,
	output logic [AW-1:0]       addr
);

	localparam int SPW = svps_pkg::SPW;

	logic signed [SPW-1:0] x_q, y_q;
	logic signed [1:0]     dx_q, dy_q;
	logic signed [1:0]     ndx, ndy;
	logic                  turn;
	logic signed [SPW-1:0] hw, hh;
	logic signed [SPW-1:0] ix, iy;
	logic                  in_box, in_img;

	// corner detection of the square spiral
	always_comb begin
		turn = (x_q == y_q)
		    || (x_q < 0 && x_q == -y_q)
		    || (x_q > 0 && x_q == ($signed(SPW'(1)) - y_q));
		ndx  = turn ? -dy_q : dx_q;
		ndy  = turn ? dx_q : dy_q;
	end

	// spiral state, reloaded per search, advanced once per probe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q  <= '0;
			y_q  <= '0;
			dx_q <= 2'sd0;
			dy_q <= -2'sd1;
		end else if (ctl.load) begin
			x_q  <= '0;
			y_q  <= '0;
			dx_q <= 2'sd0;
			dy_q <= -2'sd1;
		end else if (ctl.step) begin
			x_q  <= x_q + SPW'(ndx);
			y_q  <= y_q + SPW'(ndy);
			dx_q <= ndx;
			dy_q <= ndy;
		end
	end

	// box half sizes and absolute pixel
	assign hw = $signed({3'b000, geom.box_cols[svps_pkg::DIM_W-1:1]});
	assign hh = $signed({3'b000, geom.box_rows[svps_pkg::DIM_W-1:1]});
	assign ix = $signed({3'b000, geom.ctr_col}) + x_q;
	assign iy = $signed({3'b000, geom.ctr_row}) + y_q;

	// eligibility of the current position
	assign in_box = (x_q > -hw) && (x_q <= hw) && (y_q > -hh) && (y_q <= hh);
	assign in_img = !ix[SPW-1] && (ix[SPW-2:0] < (SPW-1)'(geom.img_cols))
	             && !iy[SPW-1] && (iy[SPW-2:0] < (SPW-1)'(geom.img_rows));

	assign probe.elig = in_box && in_img;
	assign probe.col  = ix[svps_pkg::COORD_W-1:0];
	assign probe.row  = iy[svps_pkg::COORD_W-1:0];

	// map address, row major
	assign addr = AW'(32'(iy[SPW-2:0]) * MAX_COLS + 32'(ix[SPW-2:0]));

endmodule

[rtl/spiral_valid_point_search_core.sv]
`timescale 1ns / 1ps
// Spiral valid point search core: valid-bit map memory, search sequencer,
// result register and configuration port. Depends on svps_pkg, svps_ram, svps_walker.
//
// A write word (tuser 0) stores one valid bit for pixel (col,row). A search word
// (tuser 1) passes a setup state that forms the step count max(box_cols,box_rows)^2,
// then one map read per spiral step, a check of the last read and the close of the
// walk; a hit ends the walk early. A result still waiting on the output holds the
// walk until it is taken. The single-port read of the map memory sets one step per
// cycle while the output is free.
// After reset the map memory is cleared one entry per cycle; no word is accepted
// during the clear, while configuration writes are taken always.
// A search result waiting on the output does not block write words.
module spiral_valid_point_search_core #(
	parameter int MAX_COLS = 256,
	parameter int MAX_ROWS = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// col[7:0], row[15:8], coord_x_bits[47:16], coord_y_bits[79:48],
	// coord_z_bits[111:80], box_cols[120:112], box_rows[129:121], zero pad
	input  logic [svps_pkg::S_DATA_W-1:0]  s_tdata,
	// req_type[0]
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// found_col[7:0], found_row[15:8]
	output logic [svps_pkg::M_DATA_W-1:0]  m_tdata,
	// found[0]
	output logic                           m_tuser,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [svps_pkg::CFG_AW-1:0]    paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	localparam int DEPTH   = MAX_COLS * MAX_ROWS;
	localparam int AW      = $clog2(DEPTH);
	localparam int DIM_W   = svps_pkg::DIM_W;
	localparam int LIM_W   = svps_pkg::LIM_W;
	localparam int COORD_W = svps_pkg::COORD_W;

	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_SETUP  = 4'b0100,
		ST_SEARCH = 4'b1000
	} state_t;

	state_t                state_q;
	logic [AW-1:0]         clr_q;
	logic [DIM_W-1:0]      img_cols_q, img_rows_q;
	svps_pkg::geom_t       geom_q;
	logic [DIM_W-1:0]      big_q;
	logic [LIM_W-1:0]      limit_q, steps_q;
	logic                  s1_vld_q;
	svps_pkg::probe_t      probe_s1;
	logic                  m_tvalid_q, found_q;
	logic [COORD_W-1:0]    fcol_q, frow_q;

	logic                  in_acc, is_search;
	logic [COORD_W-1:0]    in_col, in_row;
	logic [DIM_W-1:0]      in_bc, in_br, sw, sh, iw, ih;
	logic                  pix_ok, in_map;
	logic                  cfg_wr;
	svps_pkg::reg_idx_t    cfg_idx;
	svps_pkg::walk_ctl_t   walk_ctl;
	svps_pkg::probe_t      probe;
	logic [AW-1:0]         walk_addr;
	logic                  out_free, hit, issue, finish_nf;
	logic                  mem_we, mem_wdata, mem_re, mem_rdata;
	logic [AW-1:0]         mem_waddr;

	// input word fields
	assign in_col    = s_tdata[7:0];
	assign in_row    = s_tdata[15:8];
	assign in_bc     = s_tdata[120:112];
	assign in_br     = s_tdata[129:121];
	assign is_search = s_tuser;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;

	// finite check: exponent not all ones on all three coordinates
	assign pix_ok = (s_tdata[46:39] != 8'hFF) && (s_tdata[78:71] != 8'hFF)
	             && (s_tdata[110:103] != 8'hFF);
	assign in_map = (32'(in_col) < MAX_COLS) && (32'(in_row) < MAX_ROWS);

	// saturate sizes to the map dimensions
	assign sw = (32'(in_bc) > MAX_COLS) ? DIM_W'(MAX_COLS) : in_bc;
	assign sh = (32'(in_br) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : in_br;
	assign iw = (32'(img_cols_q) > MAX_COLS) ? DIM_W'(MAX_COLS) : img_cols_q;
	assign ih = (32'(img_rows_q) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : img_rows_q;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_idx = svps_pkg::reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = (cfg_idx == svps_pkg::REG_IMAGE_COLS) ? 32'(img_cols_q)
	                                                        : 32'(img_rows_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_cols_q <= 9'd256;
			img_rows_q <= 9'd256;
		end else if (cfg_wr) begin
			case (cfg_idx)
				svps_pkg::REG_IMAGE_COLS: img_cols_q <= pwdata[DIM_W-1:0];
				svps_pkg::REG_IMAGE_ROWS: img_rows_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// search step control
	assign out_free  = !m_tvalid_q || m_tready;
	assign hit       = s1_vld_q && probe_s1.elig && mem_rdata;
	assign issue     = (state_q == ST_SEARCH) && out_free && !hit && (steps_q != limit_q);
	assign finish_nf = (state_q == ST_SEARCH) && out_free && !hit
	                && (steps_q == limit_q) && !s1_vld_q;

	assign walk_ctl.load = in_acc && is_search;
	assign walk_ctl.step = issue;

	svps_walker #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (walk_ctl),
		.geom   (geom_q),
		.probe  (probe),
		.addr   (walk_addr)
	);

	// map memory port selection
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = 1'b0;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (in_acc && !is_search && in_map) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(32'(in_row) * MAX_COLS + 32'(in_col));
			mem_wdata = pix_ok;
		end
	end
	assign mem_re = issue;

	svps_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH)
	) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (walk_addr),
		.rdata (mem_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			s1_vld_q <= 1'b0;
			steps_q  <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc && is_search) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					steps_q  <= '0;
					s1_vld_q <= 1'b0;
					state_q  <= ST_SEARCH;
				end
				ST_SEARCH: begin
					if (out_free) begin
						if (hit || finish_nf) begin
							s1_vld_q <= 1'b0;
							state_q  <= ST_IDLE;
						end else begin
							s1_vld_q <= issue;
							if (issue) begin
								steps_q <= steps_q + 1'b1;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// search geometry and step count
	always_ff @(posedge clk) begin
		if (in_acc && is_search) begin
			geom_q.ctr_col  <= in_col;
			geom_q.ctr_row  <= in_row;
			geom_q.box_cols <= sw;
			geom_q.box_rows <= sh;
			geom_q.img_cols <= iw;
			geom_q.img_rows <= ih;
			big_q           <= (sw > sh) ? sw : sh;
		end
		if (state_q == ST_SETUP) begin
			limit_q <= big_q * big_q;
		end
		if (issue) begin
			probe_s1 <= probe;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (hit && out_free && state_q == ST_SEARCH) begin
			m_tvalid_q <= 1'b1;
		end else if (finish_nf) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hit && out_free && state_q == ST_SEARCH) begin
			found_q <= 1'b1;
			fcol_q  <= probe_s1.col;
			frow_q  <= probe_s1.row;
		end else if (finish_nf) begin
			found_q <= 1'b0;
			fcol_q  <= '0;
			frow_q  <= '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = found_q;
	assign m_tdata  = {frow_q, fcol_q};

	// checks
	a_no_write_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> !mem_we)
		else $error("map written during a search");

	a_steps_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (steps_q <= limit_q))
		else $error("step count passed the limit");

	a_no_read_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!out_free |-> !mem_re)
		else $error("map read while result register is full");

	a_hit_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH && out_free && hit) |=>
			(state_q == ST_IDLE && m_tvalid_q && found_q))
		else $error("hit did not produce a found word");

	a_idle_only_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |=> (state_q == ST_CLEAR || state_q == ST_IDLE))
		else $error("left clearing pass into a search");

endmodule
